// ===== sv/cfhs_pkg.sv =====
// shared types, constants and helper functions for the csi frame header serializer
package cfhs_pkg;

  // frame layout
  localparam int HEADER_BYTES = 20;
  localparam int HDR_W        = HEADER_BYTES * 8;
  localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // field widths
  localparam int LEN_W   = 16;
  localparam int HALF_W  = LEN_W - 1;
  localparam int ANT_W   = 8;
  localparam int CAP_W   = 17;
  localparam int FREQ_W  = 13;
  localparam int SEQ_W   = 32;
  localparam int MAGIC_W = 32;
  localparam int CFG_W   = 32;
  localparam int CNT_W   = $clog2(HALF_W);

  // operation codes
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_PAYLOAD = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_NO_ROOM = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_NODE     = 2'd0;
  localparam logic [1:0] CFG_CAPACITY = 2'd1;
  localparam logic [1:0] CFG_MAGIC    = 2'd2;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 17'd65555;

  // channel plan
  localparam logic [7:0] CH_24_FIRST = 8'd1;
  localparam logic [7:0] CH_24_LAST  = 8'd13;
  localparam logic [7:0] CH_24_JAPAN = 8'd14;
  localparam logic [7:0] CH_5_FIRST  = 8'd36;
  localparam logic [7:0] CH_5_LAST   = 8'd177;
  localparam logic [FREQ_W-1:0] FREQ_24_BASE  = 13'(2412 - 5);
  localparam logic [FREQ_W-1:0] FREQ_24_JAPAN = 13'd2484;
  localparam logic [FREQ_W-1:0] FREQ_5_BASE   = 13'd5000;

  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_PAY,
    CMD_ERR
  } cmd_kind_t;

  typedef struct packed {
    logic [7:0]         node;
    logic [CAP_W-1:0]   capacity;
    logic [MAGIC_W-1:0] magic;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [7:0]         data;
    logic               last;
    logic [1:0]         status;
    logic [ANT_W-1:0]   ant;
    logic [HALF_W-1:0]  half_len;
    logic [FREQ_W-1:0]  freq;
    logic [SEQ_W-1:0]   seq;
    logic [7:0]         rssi;
    logic [7:0]         noise;
  } cmd_t;

  // channel number to center frequency in MHz, zero when unknown
  function automatic logic [FREQ_W-1:0] freq_of_channel(input logic [7:0] ch);
    logic [FREQ_W-1:0] ch5;
    logic [FREQ_W-1:0] f;
    ch5 = {{(FREQ_W-8){1'b0}}, ch} * 13'd5;
    if (ch >= CH_24_FIRST && ch <= CH_24_LAST) begin
      f = FREQ_24_BASE + ch5;
    end else if (ch == CH_24_JAPAN) begin
      f = FREQ_24_JAPAN;
    end else if (ch >= CH_5_FIRST && ch <= CH_5_LAST) begin
      f = FREQ_5_BASE + ch5;
    end else begin
      f = '0;
    end
    return f;
  endfunction

endpackage

// ===== sv/cfhs_if.sv =====
// valid/ready channel interfaces for input items and result items

interface cfhs_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [7:0]        antennas;
  logic [7:0]        channel_number;
  logic signed [7:0] rssi;
  logic signed [7:0] noise_dbm;
  logic [15:0]       payload_length;
  logic [7:0]        payload_byte;

  modport source (
    output valid, operation, antennas, channel_number, rssi, noise_dbm,
    output payload_length, payload_byte,
    input  ready
  );
  modport sink (
    input  valid, operation, antennas, channel_number, rssi, noise_dbm,
    input  payload_length, payload_byte,
    output ready
  );
endinterface

interface cfhs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic [1:0] status;

  modport source (output valid, out_byte, last, status, input ready);
  modport sink   (input valid, out_byte, last, status, output ready);
endinterface

// ===== sv/cfhs_front.sv =====
// front end: accepts items, checks start items, tracks frame and sequence state
module cfhs_front (
  input  logic            clk,
  input  logic            rst_n,
  cfhs_in_if.sink         in_ch,
  input  cfhs_pkg::cfg_t  cfg,
  input  logic            q_full,
  output logic            q_push,
  output cfhs_pkg::cmd_t  q_data
);

  logic [cfhs_pkg::SEQ_W-1:0] seq_r, seq_nxt;
  logic [cfhs_pkg::LEN_W-1:0] remaining_r, remaining_nxt;
  logic                       open_r, open_nxt;

  logic                         accept;
  logic [cfhs_pkg::ANT_W-1:0]   ant_norm;
  logic [cfhs_pkg::CAP_W-1:0]   frame_size;
  logic                         hdr_ok;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // zero antennas counts as one
  assign ant_norm   = (in_ch.antennas == '0) ? 8'd1 : in_ch.antennas;
  assign frame_size = cfhs_pkg::CAP_W'(cfhs_pkg::HEADER_BYTES) + {1'b0, in_ch.payload_length};
  assign hdr_ok     = (in_ch.payload_length != '0) && (frame_size <= cfg.capacity);

  // classify the item and build the command for the back end
  always_comb begin
    seq_nxt       = seq_r;
    remaining_nxt = remaining_r;
    open_nxt      = open_r;
    q_push        = 1'b0;
    q_data        = '0;
    q_data.kind   = cfhs_pkg::CMD_PAY;
    q_data.ant    = ant_norm;
    q_data.half_len = in_ch.payload_length[cfhs_pkg::LEN_W-1:1];
    q_data.freq   = cfhs_pkg::freq_of_channel(in_ch.channel_number);
    q_data.seq    = seq_r;
    q_data.rssi   = in_ch.rssi;
    q_data.noise  = in_ch.noise_dbm;
    q_data.data   = in_ch.payload_byte;
    if (accept) begin
      unique case (in_ch.operation)
        cfhs_pkg::OP_START: begin
          q_push = 1'b1;
          if (in_ch.payload_length == '0) begin
            q_data.kind   = cfhs_pkg::CMD_ERR;
            q_data.data   = '0;
            q_data.last   = 1'b1;
            q_data.status = cfhs_pkg::ST_EMPTY;
            open_nxt      = 1'b0;
            remaining_nxt = '0;
          end else if (!hdr_ok) begin
            q_data.kind   = cfhs_pkg::CMD_ERR;
            q_data.data   = '0;
            q_data.last   = 1'b1;
            q_data.status = cfhs_pkg::ST_NO_ROOM;
            open_nxt      = 1'b0;
            remaining_nxt = '0;
          end else begin
            q_data.kind   = cfhs_pkg::CMD_HDR;
            seq_nxt       = seq_r + 1'b1;
            open_nxt      = 1'b1;
            remaining_nxt = in_ch.payload_length;
          end
        end
        cfhs_pkg::OP_PAYLOAD: begin
          // bytes outside an open frame are dropped
          if (open_r && remaining_r != '0) begin
            q_push        = 1'b1;
            q_data.kind   = cfhs_pkg::CMD_PAY;
            q_data.last   = (remaining_r == 16'd1);
            q_data.status = cfhs_pkg::ST_OK;
            remaining_nxt = remaining_r - 1'b1;
            if (remaining_r == 16'd1) begin
              open_nxt = 1'b0;
            end
          end
        end
        cfhs_pkg::OP_CLEAR: begin
          seq_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= '0;
      remaining_r <= '0;
      open_r      <= 1'b0;
    end else begin
      seq_r       <= seq_nxt;
      remaining_r <= remaining_nxt;
      open_r      <= open_nxt;
    end
  end

  // a frame is open exactly while payload bytes are still owed
  a_open_matches_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    open_r == (remaining_r != '0))
    else $error("frame open flag disagrees with remaining count");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_seq_advances_on_header: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_data.kind == cfhs_pkg::CMD_HDR) |=> (seq_r == $past(seq_r) + 1'b1))
    else $error("sequence number did not advance after a header");

endmodule

// ===== sv/cfhs_fifo.sv =====
// short command queue between front end and back end
module cfhs_fifo #(
  parameter int DEPTH = cfhs_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cfhs_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output cfhs_pkg::cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cfhs_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/cfhs_back.sv =====
// back end: runs the subcarrier divide, sends header bytes and passes results out
module cfhs_back (
  input  logic           clk,
  input  logic           rst_n,
  input  cfhs_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  cfhs_pkg::cmd_t q_head,
  output logic           q_pop,
  cfhs_out_if.source     out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_HDR
  } state_t;

  state_t                          state_r, state_nxt;
  cfhs_pkg::cmd_t                  cur_r, cur_nxt;
  logic [cfhs_pkg::ANT_W-1:0]      div_rem_r, div_rem_nxt;
  logic [cfhs_pkg::HALF_W-1:0]     div_quo_r, div_quo_nxt;
  logic [cfhs_pkg::CNT_W-1:0]      div_cnt_r, div_cnt_nxt;
  logic [cfhs_pkg::HDR_IDX_W-1:0]  hdr_idx_r, hdr_idx_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [7:0]                      out_byte_r, out_byte_nxt;
  logic                            out_last_r, out_last_nxt;
  logic [1:0]                      out_status_r, out_status_nxt;

  logic                            can_load;
  logic [cfhs_pkg::ANT_W+1:0]      div_diff;
  logic                            div_ge;
  logic [cfhs_pkg::HDR_W-1:0]      hdr_vec;
  logic [7:0]                      hdr_byte;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last     = out_last_r;
  assign out_ch.status   = out_status_r;

  assign can_load = !out_valid_r || out_ch.ready;

  // one restoring divide step: half length over antenna count
  assign div_diff = {1'b0, div_rem_r, div_quo_r[cfhs_pkg::HALF_W-1]} - {2'b00, cur_r.ant};
  assign div_ge   = !div_diff[cfhs_pkg::ANT_W+1];

  // header image, byte zero in the low bits
  assign hdr_vec = {
    8'h00, 8'h00,
    cur_r.noise, cur_r.rssi,
    cur_r.seq,
    {(32 - cfhs_pkg::FREQ_W){1'b0}}, cur_r.freq,
    {{(16 - cfhs_pkg::HALF_W){1'b0}}, div_quo_r},
    cur_r.ant,
    cfg.node,
    cfg.magic
  };
  assign hdr_byte = hdr_vec[{hdr_idx_r, 3'b000} +: 8];

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    div_rem_nxt    = div_rem_r;
    div_quo_nxt    = div_quo_r;
    div_cnt_nxt    = div_cnt_r;
    hdr_idx_nxt    = hdr_idx_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    q_pop          = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          if (q_head.kind == cfhs_pkg::CMD_HDR) begin
            q_pop       = 1'b1;
            cur_nxt     = q_head;
            div_rem_nxt = '0;
            div_quo_nxt = q_head.half_len;
            div_cnt_nxt = cfhs_pkg::CNT_W'(cfhs_pkg::HALF_W - 1);
            state_nxt   = S_DIV;
          end else if (can_load) begin
            q_pop          = 1'b1;
            out_valid_nxt  = 1'b1;
            out_byte_nxt   = q_head.data;
            out_last_nxt   = q_head.last;
            out_status_nxt = q_head.status;
          end
        end
      end
      S_DIV: begin
        div_rem_nxt = div_ge ? div_diff[cfhs_pkg::ANT_W-1:0]
                             : {div_rem_r[cfhs_pkg::ANT_W-2:0],
                                div_quo_r[cfhs_pkg::HALF_W-1]};
        div_quo_nxt = {div_quo_r[cfhs_pkg::HALF_W-2:0], div_ge};
        if (div_cnt_r == '0) begin
          hdr_idx_nxt = '0;
          state_nxt   = S_HDR;
        end else begin
          div_cnt_nxt = div_cnt_r - 1'b1;
        end
      end
      S_HDR: begin
        if (can_load) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = hdr_byte;
          out_last_nxt   = 1'b0;
          out_status_nxt = cfhs_pkg::ST_OK;
          if (hdr_idx_r == cfhs_pkg::HDR_IDX_W'(cfhs_pkg::HEADER_BYTES - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            hdr_idx_nxt = hdr_idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    div_rem_r    <= div_rem_nxt;
    div_quo_r    <= div_quo_nxt;
    div_cnt_r    <= div_cnt_nxt;
    hdr_idx_r    <= hdr_idx_nxt;
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cur_r.ant != '0))
    else $error("divide running with zero antenna count");

  a_partial_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_rem_r < cur_r.ant))
    else $error("partial remainder not below divisor");

  a_hdr_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HDR) |->
      (hdr_idx_r < cfhs_pkg::HDR_IDX_W'(cfhs_pkg::HEADER_BYTES)))
    else $error("header byte index out of range");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command popped from an empty queue");

endmodule

// ===== sv/csi_frame_header_serializer_core.sv =====
// top level of the csi frame header serializer: config registers, front, queue, back
// Path: an accepted payload or error item passes through a queue entry and the output register;
//   a start item is queued and divided before its header bytes leave through the output register.
// Throughput: payload items flow at one per cycle while the receiver keeps ready high; a good
//   start item holds the back end to take the command, run the bit-serial divide and send 20 header bytes.
// Reset (rst_n low, synchronous): sequence number, frame state, queue and output valid
//   clear; node and magic registers go to zero, capacity to 65555.
module csi_frame_header_serializer_core #(
  parameter int QUEUE_DEPTH = cfhs_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  cfhs_in_if.sink                    in_ch,
  cfhs_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [cfhs_pkg::CFG_W-1:0] cfg_wdata
);

  cfhs_pkg::cfg_t cfg_r, cfg_nxt;

  logic           q_push;
  cfhs_pkg::cmd_t q_data;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  cfhs_pkg::cmd_t q_head;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        cfhs_pkg::CFG_NODE:     cfg_nxt.node     = cfg_wdata[7:0];
        cfhs_pkg::CFG_CAPACITY: cfg_nxt.capacity = cfg_wdata[cfhs_pkg::CAP_W-1:0];
        cfhs_pkg::CFG_MAGIC:    cfg_nxt.magic    = cfg_wdata[cfhs_pkg::MAGIC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node     <= '0;
      cfg_r.capacity <= cfhs_pkg::CAPACITY_RESET;
      cfg_r.magic    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cfhs_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  cfhs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  cfhs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== bench/tb.sv =====
// testbench for the csi frame header serializer: directed and random framed traffic checked byte by byte
module tb;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         GAP_MAX      = 10;
  localparam int         DRAIN_CYCLES = 60;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         STALL_LIMIT  = 4000;
  localparam int         RANDOM_ITEMS = 130;
  localparam int         PHASE_ITEMS  = 25;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  ant;
    logic [7:0]  chan;
    logic [7:0]  rssi;
    logic [7:0]  noise;
    logic [15:0] len;
    logic [7:0]  data;
  } csi_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } frame_byte_t;

  // frame predictor and queue of frame bytes still owed by the block
  class frame_checker;
    logic [7:0]  node;
    logic [16:0] capacity;
    logic [31:0] magic;
    logic [31:0] seq;
    logic [15:0] remaining;
    bit          frame_is_open;
    frame_byte_t pending_bytes[$];
    int errors, n_results, n_headers, n_payload, n_empty, n_no_room;

    function new();
      node = 8'd0;
      capacity = cfhs_pkg::CAPACITY_RESET;
      magic = 32'd0;
      seq = 32'd0;
      remaining = 16'd0;
      frame_is_open = 1'b0;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [31:0] value);
      case (idx)
        cfhs_pkg::CFG_NODE:     node = value[7:0];
        cfhs_pkg::CFG_CAPACITY: capacity = value[16:0];
        cfhs_pkg::CFG_MAGIC:    magic = value;
        default: ;
      endcase
    endfunction

    function logic [31:0] channel_mhz(input logic [7:0] ch);
      if (ch >= 8'd1 && ch <= 8'd13) return 32'd2412 + (32'(ch) - 32'd1) * 32'd5;
      if (ch == 8'd14) return 32'd2484;
      if (ch >= 8'd36 && ch <= 8'd177) return 32'd5000 + 32'(ch) * 32'd5;
      return 32'd0;
    endfunction

    function void push(input logic [7:0] data, input logic last, input logic [1:0] status);
      frame_byte_t b;
      b.data = data;
      b.last = last;
      b.status = status;
      pending_bytes.push_back(b);
    endfunction

    // work out the frame bytes that one accepted item causes
    function void accept_item(input csi_item_t it);
      logic [7:0]   ant;
      logic [15:0]  sub;
      logic [159:0] hdr;
      case (it.op)
        cfhs_pkg::OP_START: begin
          if (it.len == 16'd0) begin
            frame_is_open = 1'b0;
            remaining = 16'd0;
            push(8'd0, 1'b1, cfhs_pkg::ST_EMPTY);
            n_empty++;
          end else if (int'(it.len) + cfhs_pkg::HEADER_BYTES > int'(capacity)) begin
            frame_is_open = 1'b0;
            remaining = 16'd0;
            push(8'd0, 1'b1, cfhs_pkg::ST_NO_ROOM);
            n_no_room++;
          end else begin
            ant = (it.ant == 8'd0) ? 8'd1 : it.ant;
            sub = 16'(int'(it.len) / (2 * int'(ant)));
            // little-endian header, byte 0 in the low bits
            hdr = {16'h0000, it.noise, it.rssi, seq, channel_mhz(it.chan), sub, ant, node,
                   magic};
            for (int k = 0; k < cfhs_pkg::HEADER_BYTES; k++)
              push(hdr[8*k +: 8], 1'b0, cfhs_pkg::ST_OK);
            seq = seq + 32'd1;
            frame_is_open = 1'b1;
            remaining = it.len;
            n_headers++;
          end
        end
        cfhs_pkg::OP_PAYLOAD: begin
          if (frame_is_open && remaining != 16'd0) begin
            remaining = remaining - 16'd1;
            push(it.data, remaining == 16'd0, cfhs_pkg::ST_OK);
            if (remaining == 16'd0) frame_is_open = 1'b0;
            n_payload++;
          end
        end
        cfhs_pkg::OP_CLEAR: seq = 32'd0;
        default: ;
      endcase
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // compare one accepted frame byte with the oldest owed byte
    task check_byte(input frame_byte_t got);
      frame_byte_t want;
      n_results++;
      if (pending_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0d status %0d",
                         got.data, got.last, got.status));
        return;
      end
      want = pending_bytes.pop_front();
      if (got.data !== want.data)
        report($sformatf("byte %0d: data %02h, predicted %02h", n_results, got.data, want.data));
      if (got.last !== want.last)
        report($sformatf("byte %0d: last %0d, predicted %0d", n_results, got.last, want.last));
      if (got.status !== want.status)
        report($sformatf("byte %0d: status %0d, predicted %0d",
                         n_results, got.status, want.status));
    endtask
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [1:0]                 cfg_index;
  logic [cfhs_pkg::CFG_W-1:0] cfg_wdata;

  cfhs_in_if  in_ch ();
  cfhs_out_if out_ch ();

  csi_frame_header_serializer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  frame_checker chk;
  bit source_fast = 1'b0;
  bit sink_fast   = 1'b0;
  bit hold_req    = 1'b0;
  int sent_items  = 0;
  int idle_cycles = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // handshake monitor: accepted items feed the predictor, results are checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        chk.accept_item('{op: in_ch.operation, ant: in_ch.antennas,
                          chan: in_ch.channel_number, rssi: in_ch.rssi,
                          noise: in_ch.noise_dbm, len: in_ch.payload_length,
                          data: in_ch.payload_byte});
      if (out_ch.valid && out_ch.ready)
        chk.check_byte('{data: out_ch.out_byte, last: out_ch.last, status: out_ch.status});
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: %0d frame bytes still owed", chk.pending_bytes.size());
      $display("Verification failed");
      $finish;
    end
  end

  // result receiver with random stalls and one long hold-off on request
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = sink_fast ? 0 : $urandom_range(0, GAP_MAX);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  function automatic csi_item_t random_item(input logic [1:0] op);
    csi_item_t it;
    it.op = op;
    it.ant = 8'($urandom);
    it.chan = 8'($urandom);
    it.rssi = 8'($urandom);
    it.noise = 8'($urandom);
    it.len = 16'($urandom);
    it.data = 8'($urandom);
    return it;
  endfunction

  // offer one item after a random gap and hold it until accepted
  task automatic send_item(input csi_item_t it);
    int gap;
    gap = source_fast ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.operation      <= it.op;
    in_ch.antennas       <= it.ant;
    in_ch.channel_number <= it.chan;
    in_ch.rssi           <= it.rssi;
    in_ch.noise_dbm      <= it.noise;
    in_ch.payload_length <= it.len;
    in_ch.payload_byte   <= it.data;
    in_ch.valid          <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
  endtask

  task automatic send_start(input logic [7:0] ant, chan, rssi, noise, input logic [15:0] len);
    csi_item_t it;
    it = random_item(cfhs_pkg::OP_START);
    it.ant = ant;
    it.chan = chan;
    it.rssi = rssi;
    it.noise = noise;
    it.len = len;
    send_item(it);
  endtask

  task automatic send_payload(input logic [7:0] b);
    csi_item_t it;
    it = random_item(cfhs_pkg::OP_PAYLOAD);
    it.data = b;
    send_item(it);
  endtask

  task automatic send_op(input logic [1:0] op);
    send_item(random_item(op));
  endtask

  // stop offering, wait for every owed byte, then let the block settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (chk.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [cfhs_pkg::CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    chk.write_reg(idx, value);
    @(posedge clk);
  endtask

  // one random frame: mostly well formed, sometimes cut short or salted with side items
  task automatic random_frame(inout int items);
    logic [7:0] chan_marks[12];
    logic [7:0] chan;
    int         sel;
    int         len;
    int         n;
    chan_marks = '{8'd0, 8'd1, 8'd7, 8'd13, 8'd14, 8'd15, 8'd35, 8'd36, 8'd100, 8'd177,
                   8'd178, 8'd255};
    source_fast = ($urandom_range(0, 4) == 0);
    sink_fast = ($urandom_range(0, 4) == 0);
    // side items between frames
    sel = $urandom_range(0, 11);
    if (sel == 0) send_op(cfhs_pkg::OP_PAYLOAD);
    else if (sel == 1) send_op(cfhs_pkg::OP_CLEAR);
    else if (sel == 2) send_op(OP_UNUSED);
    sel = $urandom_range(0, 99);
    if (sel < 75) len = $urandom_range(1, 16);
    else if (sel < 85) len = $urandom_range(17, 48);
    else if (sel < 92) len = $urandom_range(0, 65535);
    else if (sel < 96) len = 0;
    else len = int'(chk.capacity) - cfhs_pkg::HEADER_BYTES + $urandom_range(0, 1);
    if (len < 0) len = 0;
    if (len > 65535) len = 65535;
    chan = ($urandom_range(0, 1) == 0) ? chan_marks[$urandom_range(0, 11)] : 8'($urandom);
    send_start(8'($urandom), chan, 8'($urandom), 8'($urandom), 16'(len));
    n = (len > 48) ? $urandom_range(0, 6) : len;
    if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
    items += 1 + n;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 29);
      if (sel == 0) send_op(cfhs_pkg::OP_CLEAR);
      else if (sel == 1) send_op(OP_UNUSED);
      send_payload(8'($urandom));
    end
  endtask

  // stimulus
  initial begin
    int items;
    int target;
    int phase;
    chk = new();
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = cfhs_pkg::CFG_NODE;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.operation      = cfhs_pkg::OP_START;
    in_ch.antennas       = 8'd0;
    in_ch.channel_number = 8'd0;
    in_ch.rssi           = 8'd0;
    in_ch.noise_dbm      = 8'd0;
    in_ch.payload_length = 16'd0;
    in_ch.payload_byte   = 8'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset config, stray and unused items, empty start, longest length
    send_payload(8'hFF);
    send_op(OP_UNUSED);
    send_start(8'd0, 8'd14, 8'h80, 8'h7F, 16'd0);
    send_start(8'd0, 8'd14, 8'h80, 8'h7F, 16'hFFFF);
    // new start inside the open frame abandons it
    send_start(8'hFF, 8'd177, 8'h7F, 8'h80, 16'd3);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_payload(8'h5A);
    send_payload(8'h00);
    send_op(cfhs_pkg::OP_CLEAR);
    send_start(8'd1, 8'd1, 8'h00, 8'hFF, 16'd1);
    send_payload(8'hA5);
    // clear in the middle of a frame leaves the frame alone
    send_start(8'd2, 8'd13, 8'hC4, 8'hA0, 16'd2);
    send_op(cfhs_pkg::OP_CLEAR);
    send_payload(8'h3C);
    send_payload(8'hC3);
    send_start(8'd4, 8'd36, 8'hE2, 8'h9C, 16'd1);
    send_payload(8'h81);
    wait_idle();

    // directed: zero capacity, extreme node and magic
    set_reg(cfhs_pkg::CFG_CAPACITY, 32'd0);
    set_reg(cfhs_pkg::CFG_NODE, 32'd255);
    set_reg(cfhs_pkg::CFG_MAGIC, 32'hFFFF_FFFF);
    send_start(8'd1, 8'd6, 8'h10, 8'hF0, 16'd1);
    send_start(8'd1, 8'd6, 8'h10, 8'hF0, 16'd0);
    wait_idle();

    // directed: capacity just fits a one-byte frame; no-room closes the open frame
    set_reg(cfhs_pkg::CFG_CAPACITY, 32'(cfhs_pkg::HEADER_BYTES + 1));
    send_start(8'd3, 8'd15, 8'h01, 8'h02, 16'd1);
    send_start(8'd3, 8'd255, 8'h01, 8'h02, 16'd2);
    send_payload(8'h77);
    send_start(8'd3, 8'd0, 8'hFE, 8'h7E, 16'd1);
    send_payload(8'h18);
    wait_idle();

    // random phases, each under its own register setting
    items = 0;
    phase = 0;
    while (items < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin
          set_reg(cfhs_pkg::CFG_CAPACITY, 32'(cfhs_pkg::CAPACITY_RESET));
          set_reg(cfhs_pkg::CFG_NODE, 32'($urandom_range(0, 255)));
          set_reg(cfhs_pkg::CFG_MAGIC, $urandom);
        end
        1: begin
          set_reg(cfhs_pkg::CFG_CAPACITY,
                  32'(cfhs_pkg::HEADER_BYTES + $urandom_range(4, 30)));
          set_reg(cfhs_pkg::CFG_NODE, 32'd0);
          set_reg(cfhs_pkg::CFG_MAGIC, 32'd0);
        end
        2: begin
          set_reg(cfhs_pkg::CFG_CAPACITY, 32'($urandom_range(0, 65555)));
          set_reg(cfhs_pkg::CFG_NODE, 32'($urandom_range(0, 255)));
          set_reg(cfhs_pkg::CFG_MAGIC, $urandom);
        end
        default: begin
          set_reg(cfhs_pkg::CFG_CAPACITY,
                  32'($urandom_range(cfhs_pkg::HEADER_BYTES + 16, 65555)));
          set_reg(cfhs_pkg::CFG_NODE, 32'($urandom_range(0, 255)));
          set_reg(cfhs_pkg::CFG_MAGIC, $urandom);
        end
      endcase
      // back pressure: receiver holds off while a full frame streams in
      if (phase == 0) begin
        hold_req = 1'b1;
        source_fast = 1'b1;
        send_start(8'd2, 8'd11, 8'hC8, 8'hA6, 16'd40);
        for (int i = 0; i < 40; i++) send_payload(8'($urandom));
        items += 41;
      end
      target = items + PHASE_ITEMS;
      while (items < target && items < RANDOM_ITEMS) random_frame(items);
      wait_idle();
      phase++;
    end

    $display("run: %0d items over %0d register settings, %0d headers, %0d payload bytes",
             sent_items, phase + 3, chk.n_headers, chk.n_payload);
    $display("run: %0d empty and %0d no-room errors, %0d bytes checked, %0d mismatches",
             chk.n_empty, chk.n_no_room, chk.n_results, chk.errors);
    if (chk.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
